// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/sbfn_pkg.sv =====
// ----------------------------------------------------------------------------
// sbfn_pkg
// Types and constants for the spectrum bucket fold and normalize block.
// ----------------------------------------------------------------------------
`default_nettype none

package sbfn_pkg;

   localparam int MAG_W           = 16;
   localparam int LEVEL_W         = 16;
   localparam int IDX_W           = 6;
   localparam int CNT_W           = 7;
   localparam int PROD_W          = 32;
   localparam int DIV_STEPS       = 16;
   localparam int STEP_W          = 4;
   localparam int DEF_MAX_BUCKETS = 64;

   localparam logic [CNT_W-1:0]   CNT_RESET   = 7'd64;
   localparam logic [MAG_W-1:0]   THRESHOLD   = 16'd327;
   // 65536 / 1.6
   localparam logic [PROD_W-1:0]  LEVEL_SCALE = 32'd40960;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 16'd40960;

   typedef struct packed {
      logic [MAG_W-1:0] left_magnitude;
      logic [MAG_W-1:0] right_magnitude;
      logic             last_bin;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]   bucket_index;
      logic [LEVEL_W-1:0] level;
      logic               last_bucket;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FOLD,
      ST_SCAN,
      ST_SCAN_TAIL,
      ST_READ,
      ST_LOAD,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic fold;
      logic scan_start;
      logic scan_read;
      logic emit_start;
      logic div_load;
      logic div_step;
      logic emit;
      logic frame_clear;
   } cmd_type;

   typedef struct packed {
      logic last_bin;
      logic k_last;
      logic div_done;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/core/sbfn_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbfn_ctrl
// Sequencer: bin fold, max scan, then per-bucket divide and emit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sbfn_ctrl
   import sbfn_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire status_type status,
   output logic            busy,
   output logic            rsp_valid,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            if (status.last_bin) begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            cmd.scan_read = 1'b1;
            if (status.k_last) begin
               state_in = ST_SCAN_TAIL;
            end
         end
         ST_SCAN_TAIL: begin
            // last read lands in the max register this cycle
            cmd.emit_start = 1'b1;
            state_in       = ST_READ;
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            cmd.emit  = 1'b1;
            if (status.k_last) begin
               cmd.frame_clear = 1'b1;
               state_in        = ST_IDLE;
            end else begin
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `ASSERT_NEXT(a_emit_single, clock, reset, state_ff == ST_EMIT, state_ff != ST_EMIT)
   `ASSERT_NEXT(a_frame_end, clock, reset, (state_ff == ST_EMIT) && status.k_last, !busy)

endmodule

`default_nettype wire

// ===== rtl/core/sbfn_datapath.sv =====
// ----------------------------------------------------------------------------
// sbfn_datapath
// Bucket memory, fold arithmetic, max register and bit-serial divider.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sbfn_datapath
   import sbfn_pkg::*;
#(
   parameter int MAX_BUCKETS = DEF_MAX_BUCKETS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cmd_type          cmd,
   input  wire req_type          req_data,
   input  wire logic [CNT_W-1:0] bucket_count,
   output status_type            status,
   output rsp_type               rsp_data
);

   localparam int AW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;

   logic [MAG_W-1:0]       mem [MAX_BUCKETS];
   logic [MAX_BUCKETS-1:0] valid_ff;
   logic [MAG_W-1:0]       rd_data_ff;
   logic                   rd_valid_ff;
   logic                   rd_pend_ff;

   logic [AW-1:0]          pos_ff;
   logic [AW-1:0]          idx_ff;
   logic [AW-1:0]          k_ff;
   logic [MAG_W-1:0]       avg_ff;
   logic                   last_ff;
   logic [MAG_W-1:0]       max_ff;

   logic [MAG_W-1:0]       rem_ff;
   logic [MAG_W-1:0]       lo_ff;
   logic [LEVEL_W-1:0]     quot_ff;
   logic [MAG_W-1:0]       b_ff;
   logic [STEP_W-1:0]      step_ff;

   logic [CNT_W-1:0]       cnt_eff;
   logic [AW-1:0]          idx_in;
   logic [AW-1:0]          pos_in;
   logic [MAG_W:0]         sum;
   logic [MAG_W-1:0]       avg_in;
   logic [AW-1:0]          rd_addr;
   logic [MAG_W-1:0]       bucket;
   logic [MAG_W-1:0]       fold_in;
   logic [MAG_W:0]         fold_sum;
   logic                   do_write;
   logic [PROD_W-1:0]      prod;
   logic [MAG_W:0]         trial;
   logic                   ge;
   logic [MAG_W:0]         diff;

   // clamp the count to 1..MAX_BUCKETS
   always_comb begin
      if (bucket_count == '0) begin
         cnt_eff = CNT_W'(1);
      end else if (bucket_count > CNT_W'(MAX_BUCKETS)) begin
         cnt_eff = CNT_W'(MAX_BUCKETS);
      end else begin
         cnt_eff = bucket_count;
      end
   end

   always_comb begin
      idx_in = (CNT_W'(pos_ff) < cnt_eff) ? pos_ff : '0;
      pos_in = ((CNT_W'(idx_in) + CNT_W'(1)) >= cnt_eff) ? '0 : AW'(idx_in + AW'(1));
      sum    = {1'b0, req_data.left_magnitude} + {1'b0, req_data.right_magnitude};
      avg_in = sum[MAG_W:1];
      rd_addr = cmd.accept ? idx_in : k_ff;
   end

   always_comb begin
      bucket   = rd_valid_ff ? rd_data_ff : '0;
      fold_sum = {1'b0, bucket} + {1'b0, avg_ff};
      fold_in  = (bucket == '0) ? avg_ff : fold_sum[MAG_W:1];
      do_write = cmd.fold && (avg_ff > THRESHOLD);
      prod     = PROD_W'(bucket) * LEVEL_SCALE;
      trial    = {rem_ff, lo_ff[MAG_W-1]};
      ge       = trial >= {1'b0, max_ff};
      diff     = trial - {1'b0, max_ff};
   end

   // bucket memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[idx_ff] <= fold_in;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
         rd_pend_ff  <= 1'b0;
         pos_ff      <= '0;
         k_ff        <= '0;
         step_ff     <= '0;
      end else begin
         rd_valid_ff <= valid_ff[rd_addr];
         rd_pend_ff  <= cmd.scan_read;
         if (cmd.frame_clear) begin
            valid_ff <= '0;
            pos_ff   <= '0;
         end else begin
            if (do_write) begin
               valid_ff[idx_ff] <= 1'b1;
            end
            if (cmd.accept) begin
               pos_ff <= pos_in;
            end
         end
         if (cmd.scan_start || cmd.emit_start) begin
            k_ff <= '0;
         end else if (cmd.scan_read || cmd.emit) begin
            k_ff <= AW'(k_ff + AW'(1));
         end
         if (cmd.div_load) begin
            step_ff <= '0;
         end else if (cmd.div_step) begin
            step_ff <= STEP_W'(step_ff + STEP_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         avg_ff  <= avg_in;
         idx_ff  <= idx_in;
         last_ff <= req_data.last_bin;
      end
      if (cmd.scan_start) begin
         max_ff <= '0;
      end else if (rd_pend_ff && (bucket > max_ff)) begin
         max_ff <= bucket;
      end
      if (cmd.div_load) begin
         rem_ff  <= prod[PROD_W-1:MAG_W];
         lo_ff   <= prod[MAG_W-1:0];
         quot_ff <= '0;
         b_ff    <= bucket;
      end else if (cmd.div_step) begin
         rem_ff  <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
         lo_ff   <= {lo_ff[MAG_W-2:0], 1'b0};
         quot_ff <= {quot_ff[LEVEL_W-2:0], ge};
      end
   end

   always_comb begin
      status.last_bin      = last_ff;
      status.k_last        = (CNT_W'(k_ff) + CNT_W'(1)) == cnt_eff;
      status.div_done      = step_ff == STEP_W'(DIV_STEPS - 1);
      rsp_data.bucket_index = IDX_W'(k_ff);
      // all-zero frame: pass the raw bucket through
      rsp_data.level       = (max_ff == '0) ? b_ff : quot_ff;
      rsp_data.last_bucket = status.k_last;
   end

   `ASSERT_IMPL(a_level_range, clock, reset, cmd.emit && (max_ff != '0), quot_ff <= LEVEL_MAX)

endmodule

`default_nettype wire

// ===== rtl/core/spectrum_bucket_fold_normalize_top.sv =====
// ----------------------------------------------------------------------------
// spectrum_bucket_fold_normalize_top
// Folds a frame of stereo spectrum bins into buckets and emits levels.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive req_data with start; a bin is taken when start is high and
//   busy is low. Each bin is a memory read, then a fold write, the
//   read-modify-write through the bucket memory's registered read.
//   Configuration: csr_wdata carries bucket_count, taken on csr_valid while
//   csr_ready is high; write it only while the block is idle.
//   Results: after a bin with last_bin set, the block scans the buckets,
//   then emits one transaction per bucket on rsp_valid for one cycle each.
//   Each result is read, loaded and passed through the 16-step bit-serial
//   divider before it is emitted; the next bucket's read follows its emit.
//   The receiver cannot stall; each result is valid for exactly one cycle.
//   Reset: synchronous; empties all buckets, restarts bin counting at bucket
//   zero and sets bucket_count to 64. Buckets empty again after each frame.
// ----------------------------------------------------------------------------
`default_nettype none

module spectrum_bucket_fold_normalize_top
   import sbfn_pkg::*;
#(
   parameter int MAX_BUCKETS = DEF_MAX_BUCKETS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [CNT_W-1:0] csr_wdata
);

   logic [CNT_W-1:0] bucket_count_ff;
   cmd_type          cmd;
   status_type       status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= CNT_RESET;
      end else if (csr_valid && csr_ready) begin
         bucket_count_ff <= csr_wdata;
      end
   end

   sbfn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   sbfn_datapath #(
      .MAX_BUCKETS (MAX_BUCKETS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_data     (req_data),
      .bucket_count (bucket_count_ff),
      .status       (status),
      .rsp_data     (rsp_data)
   );

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the spectrum bucket fold and normalize block. Bins go in as
// command transactions from a queue, with random idle bursts. A local
// bucket model folds every accepted bin and queues the normalized levels
// of each finished frame. A monitor checks each result strobe against the
// oldest queued level, field by field. The bucket count is rewritten
// between phases, covering the extremes and a change in the middle of a
// frame.
// ----------------------------------------------------------------------------
module tb_top;
   import sbfn_pkg::*;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   req_type          req_data = '0;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CNT_W-1:0] csr_wdata = '0;

   req_type          pending_bins[$];
   rsp_type          expected_levels[$];
   rsp_type          next_level;

   // bucket model state
   logic [MAG_W-1:0] bucket_model[DEF_MAX_BUCKETS];
   int unsigned      bin_pos = 0;
   logic [CNT_W-1:0] bucket_count_reg = CNT_RESET;

   int               idle_left = 0;
   bit               quiet = 1'b0;
   int               failures = 0;

   spectrum_bucket_fold_normalize_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      foreach (bucket_model[k]) bucket_model[k] = '0;
   end

   // Fold one accepted bin; on the last bin, queue the frame's levels.
   function automatic void fold_bin(req_type bin);
      int unsigned cnt;
      int unsigned slot;
      int unsigned avg;
      int unsigned peak;
      longint unsigned lvl;
      rsp_type res;
      cnt = (bucket_count_reg == 0) ? 1 :
            (bucket_count_reg > DEF_MAX_BUCKETS) ? DEF_MAX_BUCKETS : bucket_count_reg;
      slot = (bin_pos < cnt) ? bin_pos : 0;
      avg = (32'(bin.left_magnitude) + 32'(bin.right_magnitude)) >> 1;
      if (avg > THRESHOLD) begin
         if (bucket_model[slot] == 0)
            bucket_model[slot] = MAG_W'(avg);
         else
            bucket_model[slot] = MAG_W'((32'(bucket_model[slot]) + avg) >> 1);
      end
      bin_pos = (slot + 1 >= cnt) ? 0 : slot + 1;
      if (!bin.last_bin)
         return;
      peak = 0;
      for (int k = 0; k < cnt; k++)
         if (bucket_model[k] > peak) peak = bucket_model[k];
      for (int k = 0; k < cnt; k++) begin
         if (peak == 0)
            lvl = bucket_model[k];
         else
            lvl = (64'(bucket_model[k]) * 64'(LEVEL_SCALE)) / peak;
         if (lvl > 64'hFFFF) lvl = 64'hFFFF;
         res.bucket_index = IDX_W'(k);
         res.level        = LEVEL_W'(lvl);
         res.last_bucket  = (k + 1 == cnt);
         expected_levels = {expected_levels, res};
      end
      foreach (bucket_model[k]) bucket_model[k] = '0;
      bin_pos = 0;
   endfunction

   // driver: hold start while busy, otherwise advance or idle
   always @(posedge clock) begin
      if (reset) begin
         start     <= 1'b0;
         idle_left = 0;
      end else if (!(start && busy)) begin
         if (start)
            fold_bin(req_data);
         if (idle_left > 0) begin
            idle_left = idle_left - 1;
            start <= 1'b0;
         end else if (pending_bins.size() > 0 && !quiet && $urandom_range(0, 7) == 0) begin
            idle_left = $urandom_range(1, 13) - 1;
            start <= 1'b0;
         end else if (pending_bins.size() > 0) begin
            start    <= 1'b1;
            req_data <= pending_bins.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: every strobe is a transaction that must match the oldest level
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_levels.size() == 0) begin
            $error("unexpected result: bucket_index %0d level %0d",
                   rsp_data.bucket_index, rsp_data.level);
            failures++;
         end else begin
            next_level = expected_levels.pop_front();
            if (rsp_data.bucket_index !== next_level.bucket_index) begin
               $error("bucket_index: expected %0d, actual %0d",
                      next_level.bucket_index, rsp_data.bucket_index);
               failures++;
            end
            if (rsp_data.level !== next_level.level) begin
               $error("level: expected %0d, actual %0d", next_level.level, rsp_data.level);
               failures++;
            end
            if (rsp_data.last_bucket !== next_level.last_bucket) begin
               $error("last_bucket: expected %0d, actual %0d",
                      next_level.last_bucket, rsp_data.last_bucket);
               failures++;
            end
         end
      end
   end

   function automatic void add_bin(logic [MAG_W-1:0] l, logic [MAG_W-1:0] r, logic last);
      req_type bin;
      bin.left_magnitude  = l;
      bin.right_magnitude = r;
      bin.last_bin        = last;
      pending_bins = {pending_bins, bin};
   endfunction

   function automatic logic [MAG_W-1:0] pick_magnitude();
      case ($urandom_range(0, 9))
         0, 1: return MAG_W'($urandom_range(0, 400));
         2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         3: return 16'h8000;
         4: return MAG_W'($urandom_range(0, 65535));
         default: return MAG_W'($urandom_range(0, 32768));
      endcase
   endfunction

   task automatic wait_drained();
      while (pending_bins.size() != 0 || start || expected_levels.size() != 0)
         @(posedge clock);
   endtask

   // Write the count only once everything is drained and the fold has settled.
   task automatic write_bucket_count(input logic [CNT_W-1:0] value);
      wait_drained();
      repeat (8) @(posedge clock);
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      bucket_count_reg = value;
      csr_valid <= 1'b0;
   endtask

   initial begin
      int unsigned counts[10];
      counts = '{1, 4, 127, 9, 0, 2, 33, 5, 64, 16};
      counts[6] = $urandom_range(3, 63);
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // threshold edges, extremes of the magnitudes, then one 64-bucket frame
      add_bin(16'd0, 16'd0, 1'b0);
      add_bin(16'd327, 16'd327, 1'b0);
      add_bin(16'd328, 16'd328, 1'b0);
      add_bin(16'hFFFF, 16'hFFFF, 1'b0);
      add_bin(16'h8000, 16'h8000, 1'b0);
      add_bin(16'hFFFF, 16'h0000, 1'b0);
      add_bin(16'h0000, 16'hFFFF, 1'b1);
      // every bin below threshold: largest bucket is zero
      add_bin(16'd100, 16'd200, 1'b0);
      add_bin(16'd0, 16'd0, 1'b1);

      // fold into occupied buckets, saturating values included
      write_bucket_count(7'd2);
      add_bin(16'd1000, 16'd1000, 1'b0);
      add_bin(16'd2000, 16'd2000, 1'b0);
      add_bin(16'd3000, 16'd3000, 1'b0);
      add_bin(16'd500, 16'd500, 1'b0);
      add_bin(16'hFFFF, 16'hFFFF, 1'b0);
      add_bin(16'hFFFF, 16'hFFFF, 1'b1);

      // leave a frame open, then shrink the count below the bin position
      write_bucket_count(7'd6);
      for (int i = 0; i < 5; i++)
         add_bin(MAG_W'(400 + 100 * i), MAG_W'(600 + 100 * i), 1'b0);
      write_bucket_count(7'd3);
      add_bin(16'd5000, 16'd7000, 1'b0);
      add_bin(16'd0, 16'h8000, 1'b1);

      // count of zero acts as one, all ones acts as the maximum
      write_bucket_count(7'd0);
      add_bin(16'd12345, 16'd54321, 1'b1);
      write_bucket_count(7'd127);
      add_bin(16'h8000, 16'd0, 1'b1);

      foreach (counts[p]) begin
         write_bucket_count(CNT_W'(counts[p]));
         quiet = (p == 9);
         repeat (45)
            add_bin(pick_magnitude(), pick_magnitude(), $urandom_range(0, 7) == 0);
      end

      wait_drained();
      repeat (1400) @(posedge clock);
      if (failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #30_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
